FILE: hdl/dtcf_pkg.sv
// ----------------------------------------------------------------------------
// DMA tag chain follower package
// Shared constants, error codes, tag kinds and the range check result type.
// ----------------------------------------------------------------------------
package dtcf_pkg;

    // Field widths.
    localparam int unsigned OFF_W  = 26;
    localparam int unsigned ADDR_W = 31;
    localparam int unsigned SIZE_W = 20;
    localparam int unsigned SUM_W  = 32;

    // Main memory size in bytes; the usable limit never exceeds it.
    localparam logic [OFF_W-1:0] MAIN_MEM_BYTES = 26'd33554432;

    // Decoded tag kinds.
    localparam logic [2:0] KIND_CNT  = 3'd0;
    localparam logic [2:0] KIND_NEXT = 3'd1;
    localparam logic [2:0] KIND_REF  = 3'd2;
    localparam logic [2:0] KIND_REFS = 3'd3;

    // Error codes reported with each result.
    localparam logic [3:0] ERR_NONE     = 4'd0;
    localparam logic [3:0] ERR_BAD_OFF  = 4'd1;
    localparam logic [3:0] ERR_REVISIT  = 4'd2;
    localparam logic [3:0] ERR_FULL     = 4'd3;
    localparam logic [3:0] ERR_SPR      = 4'd4;
    localparam logic [3:0] ERR_KIND     = 4'd5;
    localparam logic [3:0] ERR_CNT_ADDR = 4'd6;
    localparam logic [3:0] ERR_DATA     = 4'd7;
    localparam logic [3:0] ERR_NEXT     = 4'd8;

    // Configuration register indexes (taken from paddr bit 2).
    localparam logic CFG_MEM_LIMIT = 1'b0;
    localparam logic CFG_START_OFF = 1'b1;

    // Result of the shared range unit.
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             fits;
        logic             aligned;
    } t_range_res;

endpackage

FILE: hdl/dtcf_range_unit.sv
// ----------------------------------------------------------------------------
// Range unit
// Shared add-and-compare unit: base plus length against the memory limit,
// with a 16-byte alignment check of the base.
// ----------------------------------------------------------------------------
module dtcf_range_unit (
    input  logic [dtcf_pkg::ADDR_W-1:0] i_base,
    input  logic [dtcf_pkg::SIZE_W-1:0] i_len,
    input  logic [dtcf_pkg::OFF_W-1:0]  i_limit,
    output dtcf_pkg::t_range_res        o_res
);
    import dtcf_pkg::*;

    logic [SUM_W-1:0] w_sum;

    // One wide add, one compare against the limit.
    always_comb begin
        w_sum         = SUM_W'(i_base) + SUM_W'(i_len);
        o_res.sum     = w_sum;
        o_res.fits    = (w_sum <= SUM_W'(i_limit));
        o_res.aligned = (i_base[3:0] == 4'd0);
    end

endmodule

FILE: hdl/dtcf_visit_mem.sv
// ----------------------------------------------------------------------------
// Visited offset store
// Single write port, single registered read port memory of tag offsets.
// ----------------------------------------------------------------------------
module dtcf_visit_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [dtcf_pkg::OFF_W-1:0] i_wr_data,
    input  logic                       i_rd_en,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [dtcf_pkg::OFF_W-1:0] o_rd_data
);
    import dtcf_pkg::*;

    logic [OFF_W-1:0] r_mem [DEPTH];
    logic [OFF_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/dma_tag_chain_follower_core.sv
// ----------------------------------------------------------------------------
// DMA tag chain follower core
// Walks a chain of decoded DMA tags, rejects revisited or malformed tags and
// reports the payload transfer of each accepted tag.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                     Payload
// in        sink       i_in_valid / o_in_ready       i_action, i_tag_*, i_vif_word*
// out       source     o_out_valid / i_out_ready     o_ok, o_error_code, offsets, ...
// cfg       APB slave  psel, penable, pwrite, pready paddr, pwdata, prdata
//
// A tag has its offset checked, is scanned against the N offsets already visited,
// one entry per cycle through the store's single registered read port, and then
// is checked for a full store and for its data and next ranges; the shared range
// unit runs three checks in turn. Reset clears the offset, the visit count and the
// output valid. A result waits in the output register while the next transfer is
// taken in; processing stalls only at its end if that result is not taken.
// ----------------------------------------------------------------------------
module dma_tag_chain_follower_core #(
    parameter int unsigned VISIT_DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // Input channel.
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_action,
    input  logic [2:0]                  i_tag_kind,
    input  logic [15:0]                 i_tag_qwc,
    input  logic [dtcf_pkg::ADDR_W-1:0] i_tag_addr,
    input  logic                        i_tag_spr,
    input  logic [31:0]                 i_vif_word0,
    input  logic [31:0]                 i_vif_word1,
    // Output channel.
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_ok,
    output logic [3:0]                  o_error_code,
    output logic [dtcf_pkg::OFF_W-1:0]  o_tag_off,
    output logic [dtcf_pkg::OFF_W-1:0]  o_data_off,
    output logic [dtcf_pkg::SIZE_W-1:0] o_byte_count,
    output logic [31:0]                 o_vif_out0,
    output logic [31:0]                 o_vif_out1,
    output logic [dtcf_pkg::OFF_W-1:0]  o_current_offset
);
    import dtcf_pkg::*;

    localparam int unsigned AW = (VISIT_DEPTH > 1) ? $clog2(VISIT_DEPTH) : 1;
    localparam int unsigned CW = $clog2(VISIT_DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_CHK_OFF  = 7'b0000010,
        S_SCAN     = 7'b0000100,
        S_CHK_FULL = 7'b0001000,
        S_DATA     = 7'b0010000,
        S_NEXT     = 7'b0100000,
        S_DONE     = 7'b1000000
    } t_state;

    // Control state.
    t_state             r_state, n_state;
    logic [OFF_W-1:0]   r_offset, n_offset;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_idx, n_idx;
    logic [OFF_W-1:0]   r_mem_limit, r_start_off;
    logic               r_out_valid;

    // Working item registers.
    logic               r_action;
    logic [2:0]         r_kind;
    logic [SIZE_W-1:0]  r_size;
    logic [ADDR_W-1:0]  r_addr;
    logic               r_spr;
    logic [31:0]        r_v0, r_v1;
    logic [OFF_W-1:0]   r_tag_off;
    logic [3:0]         r_err, n_err;
    logic [ADDR_W-1:0]  r_data, n_data;
    logic [ADDR_W-1:0]  r_next, n_next;

    // Output registers.
    logic               r_o_ok;
    logic [3:0]         r_o_err;
    logic [OFF_W-1:0]   r_o_tag_off, r_o_data_off, r_o_cur_off;
    logic [SIZE_W-1:0]  r_o_size;
    logic [31:0]        r_o_v0, r_o_v1;

    // Datapath signals.
    logic               w_in_xfer;
    logic               w_out_load;
    logic               w_cfg_wr;
    logic [OFF_W-1:0]   w_limit;
    logic [ADDR_W-1:0]  w_rng_base;
    logic [SIZE_W-1:0]  w_rng_len;
    t_range_res         w_rng;
    logic [CW-1:0]      w_idx_nxt;
    logic               w_rd_en;
    logic [AW-1:0]      w_rd_addr;
    logic               w_wr_en;
    logic [OFF_W-1:0]   w_rd_data;
    logic               w_ok;

    // Handshakes.
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_out_load  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    // Configuration registers.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_limit <= MAIN_MEM_BYTES;
            r_start_off <= '0;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                CFG_MEM_LIMIT: r_mem_limit <= pwdata[OFF_W-1:0];
                CFG_START_OFF: r_start_off <= pwdata[OFF_W-1:0];
                default:       r_mem_limit <= r_mem_limit;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            CFG_MEM_LIMIT: prdata = 32'(r_mem_limit);
            CFG_START_OFF: prdata = 32'(r_start_off);
            default:       prdata = '0;
        endcase
    end

    // Usable limit, clamped to main memory.
    assign w_limit = (r_mem_limit > MAIN_MEM_BYTES) ? MAIN_MEM_BYTES : r_mem_limit;

    // Operand selection for the shared range unit.
    always_comb begin
        case (r_state)
            S_CHK_OFF: begin
                w_rng_base = ADDR_W'(r_offset);
                w_rng_len  = SIZE_W'(16);
            end
            S_DATA: begin
                w_rng_base = r_data;
                w_rng_len  = r_size;
            end
            default: begin
                w_rng_base = r_next;
                w_rng_len  = '0;
            end
        endcase
    end

    dtcf_range_unit u_range (
        .i_base  (w_rng_base),
        .i_len   (w_rng_len),
        .i_limit (w_limit),
        .o_res   (w_rng)
    );

    // Visited store: read during the scan, written when the offset is recorded.
    assign w_idx_nxt = r_idx + CW'(1);
    assign w_rd_en   = (r_state == S_CHK_OFF) || (r_state == S_SCAN);
    assign w_rd_addr = (r_state == S_SCAN) ? w_idx_nxt[AW-1:0] : '0;
    assign w_wr_en   = (r_state == S_CHK_FULL) && (r_count < CW'(VISIT_DEPTH));

    dtcf_visit_mem #(
        .DEPTH (VISIT_DEPTH),
        .AW    (AW)
    ) u_visit_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (r_offset),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        n_offset = r_offset;
        n_count  = r_count;
        n_idx    = r_idx;
        n_err    = r_err;
        n_data   = r_data;
        n_next   = r_next;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_err = ERR_NONE;
                    if (!i_action) begin
                        n_offset = r_start_off;
                        n_count  = '0;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_CHK_OFF;
                    end
                end
            end
            S_CHK_OFF: begin
                // Offset plus one tag must fit and be aligned.
                n_data = w_rng.sum[ADDR_W-1:0];
                n_idx  = '0;
                if (!w_rng.fits || !w_rng.aligned) begin
                    n_err   = ERR_BAD_OFF;
                    n_state = S_DONE;
                end else if (r_count == '0) begin
                    n_state = S_CHK_FULL;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // One stored offset compared per cycle.
                if (w_rd_data == r_offset) begin
                    n_err   = ERR_REVISIT;
                    n_state = S_DONE;
                end else if (w_idx_nxt == r_count) begin
                    n_state = S_CHK_FULL;
                end else begin
                    n_idx = w_idx_nxt;
                end
            end
            S_CHK_FULL: begin
                if (r_count >= CW'(VISIT_DEPTH)) begin
                    n_err   = ERR_FULL;
                    n_state = S_DONE;
                end else begin
                    // Offset is recorded, and the tag fields are checked in the same state.
                    n_count = r_count + CW'(1);
                    if (r_spr) begin
                        n_err   = ERR_SPR;
                        n_state = S_DONE;
                    end else if (r_kind[2]) begin
                        n_err   = ERR_KIND;
                        n_state = S_DONE;
                    end else if (r_kind == KIND_CNT && r_addr != '0) begin
                        n_err   = ERR_CNT_ADDR;
                        n_state = S_DONE;
                    end else begin
                        // r_data holds offset plus 16 here.
                        case (r_kind)
                            KIND_NEXT: n_next = r_addr;
                            KIND_REF, KIND_REFS: begin
                                n_data = r_addr;
                                n_next = r_data;
                            end
                            default:   n_next = r_data;
                        endcase
                        n_state = S_DATA;
                    end
                end
            end
            S_DATA: begin
                // Payload range; a CNT tag's next offset is the payload end.
                if (r_kind == KIND_CNT) begin
                    n_next = w_rng.sum[ADDR_W-1:0];
                end
                if (!w_rng.fits) begin
                    n_err   = ERR_DATA;
                    n_state = S_DONE;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (!w_rng.fits || !w_rng.aligned) begin
                    n_err = ERR_NEXT;
                end else begin
                    n_offset = r_next[OFF_W-1:0];
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_offset    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_offset <= n_offset;
            r_count  <= n_count;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers of the current transfer.
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_err  <= n_err;
        r_data <= n_data;
        r_next <= n_next;
        if (w_in_xfer) begin
            r_action  <= i_action;
            r_kind    <= i_tag_kind;
            r_size    <= {i_tag_qwc, 4'd0};
            r_addr    <= i_tag_addr;
            r_spr     <= i_tag_spr;
            r_v0      <= i_vif_word0;
            r_v1      <= i_vif_word1;
            r_tag_off <= r_offset;
        end
    end

    // Output register: payload fields are zero unless the tag was followed.
    assign w_ok = r_action && (r_err == ERR_NONE);

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_ok       <= w_ok;
            r_o_err      <= r_err;
            r_o_tag_off  <= r_action ? r_tag_off : '0;
            r_o_data_off <= w_ok ? r_data[OFF_W-1:0] : '0;
            r_o_size     <= w_ok ? r_size : '0;
            r_o_v0       <= w_ok ? r_v0 : '0;
            r_o_v1       <= w_ok ? r_v1 : '0;
            r_o_cur_off  <= r_offset;
        end
    end

    assign o_ok             = r_o_ok;
    assign o_error_code     = r_o_err;
    assign o_tag_off        = r_o_tag_off;
    assign o_data_off       = r_o_data_off;
    assign o_byte_count     = r_o_size;
    assign o_vif_out0       = r_o_v0;
    assign o_vif_out1       = r_o_v1;
    assign o_current_offset = r_o_cur_off;

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DMA tag chain follower core regression
// Drives decoded tags and chain restarts through the valid/ready input channel
// and checks every output transfer against a tag walk predictor kept in this
// bench. A short directed table covers boundaries and all codes but ERR_FULL,
// then random chain walks run under several memory limits, start offsets and
// handshake idling patterns. The configuration port is written between phases.
// ----------------------------------------------------------------------------
module testbench;
    import dtcf_pkg::*;

    // Item actions and the unsupported tag kind range.
    localparam logic       ACT_RESTART  = 1'b0;
    localparam logic       ACT_TAG      = 1'b1;
    localparam logic [2:0] KIND_RSVD_LO = 3'd4;
    localparam logic [2:0] KIND_RSVD_HI = 3'd7;

    localparam int unsigned VISITS      = 64;
    localparam int unsigned IDLE_PCT    = 73;
    localparam int unsigned BOTH_PCT    = 36;
    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned DRAIN_CYCLES = 100;

    localparam logic [31:0] W_ONES = 32'hFFFF_FFFF;
    localparam logic [31:0] W_ZERO = 32'h0000_0000;

    typedef struct packed {
        logic              action;
        logic [2:0]        kind;
        logic [15:0]       qwc;
        logic [ADDR_W-1:0] addr;
        logic              spr;
        logic [31:0]       word0;
        logic [31:0]       word1;
    } t_tag_item;

    typedef struct packed {
        logic              ok;
        logic [3:0]        err;
        logic [OFF_W-1:0]  tag_off;
        logic [OFF_W-1:0]  data_off;
        logic [SIZE_W-1:0] size;
        logic [31:0]       out0;
        logic [31:0]       out1;
        logic [OFF_W-1:0]  cur;
    } t_walk_result;

    typedef struct packed {
        t_tag_item    stim;
        logic         fixed;
        t_walk_result want;
    } t_dir_row;

    typedef struct packed {
        logic [OFF_W-1:0] limit;
        logic [OFF_W-1:0] start;
        int unsigned      send_pct;
        int unsigned      recv_pct;
        int unsigned      count;
    } t_walk_phase;

    localparam t_walk_result NO_CHECK = '0;
    localparam int unsigned  DIR_ROWS = 23;
    localparam int unsigned  PHASES   = 10;

    // Directed rows, all under the reset configuration (full memory, start 0).
    // Rows with a typed-in result are boundary or error cases; the rest are
    // checked against the predictor.
    t_dir_row dir_table [DIR_ROWS] = '{
        // First tag after reset: empty CNT at offset zero.
        '{'{ACT_TAG, KIND_CNT, 16'h0000, 31'h0, 1'b0, W_ONES, W_ONES}, 1'b1,
          '{1'b1, ERR_NONE, 26'h0, 26'h10, 20'h0, W_ONES, W_ONES, 26'h10}},
        '{'{ACT_RESTART, KIND_CNT, 16'h0000, 31'h0, 1'b0, W_ZERO, W_ZERO}, 1'b1,
          '{1'b0, ERR_NONE, 26'h0, 26'h0, 20'h0, W_ZERO, W_ZERO, 26'h0}},
        // Largest payload referenced at address zero.
        '{'{ACT_TAG, KIND_REF, 16'hFFFF, 31'h0, 1'b0, W_ZERO, W_ZERO}, 1'b1,
          '{1'b1, ERR_NONE, 26'h0, 26'h0, 20'hFFFF0, W_ZERO, W_ZERO, 26'h10}},
        // Scratchpad flag, then the same offset seen again.
        '{'{ACT_TAG, KIND_CNT, 16'h0000, 31'h0, 1'b1, 32'h1234_5678, 32'h9ABC_DEF0},
          1'b1, '{1'b0, ERR_SPR, 26'h10, 26'h0, 20'h0, W_ZERO, W_ZERO, 26'h10}},
        '{'{ACT_TAG, KIND_CNT, 16'h0000, 31'h0, 1'b0, W_ONES, W_ONES}, 1'b1,
          '{1'b0, ERR_REVISIT, 26'h10, 26'h0, 20'h0, W_ZERO, W_ZERO, 26'h10}},
        '{'{ACT_RESTART, KIND_CNT, 16'h0000, 31'h0, 1'b0, W_ZERO, W_ZERO}, 1'b1,
          '{1'b0, ERR_NONE, 26'h0, 26'h0, 20'h0, W_ZERO, W_ZERO, 26'h0}},
        // Unsupported kind.
        '{'{ACT_TAG, KIND_RSVD_LO, 16'h0000, 31'h0, 1'b0, W_ONES, W_ONES}, 1'b1,
          '{1'b0, ERR_KIND, 26'h0, 26'h0, 20'h0, W_ZERO, W_ZERO, 26'h0}},
        '{'{ACT_RESTART, KIND_CNT, 16'h0000, 31'h0, 1'b0, W_ZERO, W_ZERO}, 1'b1,
          '{1'b0, ERR_NONE, 26'h0, 26'h0, 20'h0, W_ZERO, W_ZERO, 26'h0}},
        // CNT tag carrying an address.
        '{'{ACT_TAG, KIND_CNT, 16'h0000, 31'h1, 1'b0, W_ONES, W_ONES}, 1'b1,
          '{1'b0, ERR_CNT_ADDR, 26'h0, 26'h0, 20'h0, W_ZERO, W_ZERO, 26'h0}},
        '{'{ACT_RESTART, KIND_CNT, 16'h0000, 31'h0, 1'b0, W_ZERO, W_ZERO}, 1'b1,
          '{1'b0, ERR_NONE, 26'h0, 26'h0, 20'h0, W_ZERO, W_ZERO, 26'h0}},
        // Referenced data at the top of the address field.
        '{'{ACT_TAG, KIND_REFS, 16'h0000, 31'h7FFF_FFFF, 1'b0, W_ONES, W_ONES}, 1'b1,
          '{1'b0, ERR_DATA, 26'h0, 26'h0, 20'h0, W_ZERO, W_ZERO, 26'h0}},
        '{'{ACT_RESTART, KIND_CNT, 16'h0000, 31'h0, 1'b0, W_ZERO, W_ZERO}, 1'b1,
          '{1'b0, ERR_NONE, 26'h0, 26'h0, 20'h0, W_ZERO, W_ZERO, 26'h0}},
        // Misaligned next pointer.
        '{'{ACT_TAG, KIND_NEXT, 16'h0000, 31'h8, 1'b0, W_ONES, W_ONES}, 1'b1,
          '{1'b0, ERR_NEXT, 26'h0, 26'h0, 20'h0, W_ZERO, W_ZERO, 26'h0}},
        '{'{ACT_RESTART, KIND_CNT, 16'h0000, 31'h0, 1'b0, W_ZERO, W_ZERO}, 1'b1,
          '{1'b0, ERR_NONE, 26'h0, 26'h0, 20'h0, W_ZERO, W_ZERO, 26'h0}},
        // Next pointer exactly at the end of memory, then a tag there.
        '{'{ACT_TAG, KIND_NEXT, 16'h0000, 31'h200_0000, 1'b0, 32'hAAAA_AAAA,
            32'h5555_5555}, 1'b1,
          '{1'b1, ERR_NONE, 26'h0, 26'h10, 20'h0, 32'hAAAA_AAAA, 32'h5555_5555,
            26'h200_0000}},
        '{'{ACT_TAG, KIND_CNT, 16'h0000, 31'h0, 1'b0, W_ONES, W_ONES}, 1'b1,
          '{1'b0, ERR_BAD_OFF, 26'h200_0000, 26'h0, 20'h0, W_ZERO, W_ZERO,
            26'h200_0000}},
        '{'{ACT_RESTART, KIND_RSVD_HI, 16'hFFFF, 31'h7FFF_FFFF, 1'b1, W_ONES, W_ONES},
          1'b0, NO_CHECK},
        '{'{ACT_TAG, KIND_RSVD_HI, 16'h0000, 31'h0, 1'b0, W_ONES, W_ONES}, 1'b0,
          NO_CHECK},
        '{'{ACT_RESTART, KIND_CNT, 16'h0000, 31'h0, 1'b0, W_ZERO, W_ZERO}, 1'b0,
          NO_CHECK},
        '{'{ACT_TAG, KIND_CNT, 16'hFFFF, 31'h0, 1'b0, 32'h0F0F_0F0F, 32'hF0F0_F0F0},
          1'b0, NO_CHECK},
        '{'{ACT_TAG, KIND_REF, 16'h0001, 31'h1FF_FFF0, 1'b0, W_ONES, W_ZERO}, 1'b0,
          NO_CHECK},
        '{'{ACT_TAG, KIND_NEXT, 16'h0000, 31'h4000_0000, 1'b0, W_ZERO, W_ONES}, 1'b0,
          NO_CHECK},
        '{'{ACT_TAG, KIND_REFS, 16'h0002, 31'h1FF_FFF0, 1'b0, W_ONES, W_ONES}, 1'b0,
          NO_CHECK}
    };

    // Random phases: memory limit, start offset, sender idle and receiver
    // stall percentages, item count. The first one keeps the reset values.
    t_walk_phase phase_table [PHASES] = '{
        '{26'h200_0000, 26'h0,         0,        0,        300},
        '{26'h3FF_FFFF, 26'h1000,      IDLE_PCT, 0,        250},
        '{26'd4096,     26'h0,         0,        IDLE_PCT, 200},
        '{26'h200_0000, 26'h1FF_FFF0,  BOTH_PCT, BOTH_PCT, 150},
        '{26'h0,        26'h0,         0,        0,        50},
        '{26'h8_0000,   26'h123,       IDLE_PCT, 0,        50},
        '{26'h100_0000, 26'h3FF_FFFF,  BOTH_PCT, BOTH_PCT, 50},
        '{26'h200_0000, 26'h10,        BOTH_PCT, BOTH_PCT, 300},
        '{26'h1_2345,   26'h100,       0,        IDLE_PCT, 200},
        '{26'h1FF_FF00, 26'h40,        0,        0,        230}
    };

    // Block ports.
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [2:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_action = ACT_RESTART;
    logic [2:0]           i_tag_kind = '0;
    logic [15:0]          i_tag_qwc = '0;
    logic [ADDR_W-1:0]    i_tag_addr = '0;
    logic                 i_tag_spr = 1'b0;
    logic [31:0]          i_vif_word0 = '0;
    logic [31:0]          i_vif_word1 = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic                 o_ok;
    logic [3:0]           o_error_code;
    logic [OFF_W-1:0]     o_tag_off;
    logic [OFF_W-1:0]     o_data_off;
    logic [SIZE_W-1:0]    o_byte_count;
    logic [31:0]          o_vif_out0;
    logic [31:0]          o_vif_out1;
    logic [OFF_W-1:0]     o_current_offset;

    // Walker state as predicted, plus configuration copies.
    logic [OFF_W-1:0]     cfg_limit = MAIN_MEM_BYTES;
    logic [OFF_W-1:0]     cfg_start = '0;
    logic [OFF_W-1:0]     walk_off = '0;
    logic [OFF_W-1:0]     seen_offs [VISITS];
    int unsigned          seen_cnt = 0;

    // Stimulus shaping and bookkeeping.
    int unsigned          send_idle_pct = 0;
    int unsigned          recv_stall_pct = 0;
    bit                   last_failed = 1'b0;
    bit                   clean_chain = 1'b0;
    int unsigned          mismatches = 0;
    int unsigned          quiet_cycles = 0;
    t_walk_result         due_results [$];

    dma_tag_chain_follower_core #(.VISIT_DEPTH(VISITS)) uut (.*);

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint unsigned usable_limit();
        return (cfg_limit < MAIN_MEM_BYTES) ? longint'(cfg_limit) : longint'(MAIN_MEM_BYTES);
    endfunction

    function automatic bit span_fits(longint unsigned base, longint unsigned len,
                                     longint unsigned lim);
        return (base <= lim) && (len <= lim - base);
    endfunction

    // Predicts the result of one item and advances the walker state.
    function automatic t_walk_result follow_tag(t_tag_item it);
        t_walk_result    r;
        longint unsigned lim;
        longint unsigned off;
        longint unsigned size;
        longint unsigned data;
        longint unsigned nxt;
        logic [3:0]      err;
        r    = '0;
        data = 0;
        nxt  = 0;
        lim  = usable_limit();
        if (it.action == ACT_RESTART) begin
            walk_off = cfg_start;
            seen_cnt = 0;
            r.cur    = walk_off;
            return r;
        end
        off       = longint'(walk_off);
        size      = longint'(it.qwc) * 16;
        err       = ERR_NONE;
        r.tag_off = walk_off;

        // Offset checks come first; a passing offset is recorded.
        if (!span_fits(off, 16, lim) || off[3:0] != 4'd0) begin
            err = ERR_BAD_OFF;
        end else begin
            for (int unsigned i = 0; i < seen_cnt; i++) begin
                if (seen_offs[i] == walk_off) err = ERR_REVISIT;
            end
            if (err == ERR_NONE && seen_cnt >= VISITS) err = ERR_FULL;
        end
        if (err == ERR_NONE) begin
            seen_offs[seen_cnt] = walk_off;
            seen_cnt++;
            if (it.spr) err = ERR_SPR;
            else if (it.kind > KIND_REFS) err = ERR_KIND;
            else if (it.kind == KIND_CNT && it.addr != '0) err = ERR_CNT_ADDR;
        end

        // Payload placement and the next tag offset.
        if (err == ERR_NONE) begin
            case (it.kind)
                KIND_CNT: begin
                    data = off + 16;
                    nxt  = data + size;
                end
                KIND_NEXT: begin
                    data = off + 16;
                    nxt  = longint'(it.addr);
                end
                default: begin
                    data = longint'(it.addr);
                    nxt  = off + 16;
                end
            endcase
            if (!span_fits(data, size, lim)) err = ERR_DATA;
            else if (nxt[3:0] != 4'd0 || nxt > lim) err = ERR_NEXT;
        end

        if (err != ERR_NONE) begin
            r.err = err;
            r.cur = walk_off;
            return r;
        end
        walk_off   = nxt[OFF_W-1:0];
        r.ok       = 1'b1;
        r.data_off = data[OFF_W-1:0];
        r.size     = size[SIZE_W-1:0];
        r.out0     = it.word0;
        r.out1     = it.word1;
        r.cur      = walk_off;
        return r;
    endfunction

    // Builds the next random item from the predicted walker state. Most items
    // continue a well-formed chain; clean chains run forward until memory or
    // the visited store runs out, the others mix in revisits and broken tags.
    function automatic t_tag_item pick_walk_item();
        t_tag_item   it;
        int unsigned lim;
        int unsigned off;
        int unsigned maxq;
        int unsigned size;
        int unsigned nxt;
        int unsigned roll;
        lim       = 32'(usable_limit());
        off       = 32'(walk_off);
        it.action = ACT_TAG;
        it.kind   = 3'($urandom_range(32'(KIND_REFS)));
        it.qwc    = '0;
        it.addr   = '0;
        it.spr    = 1'b0;
        it.word0  = $urandom();
        it.word1  = $urandom();

        // Restart mostly after an error.
        roll = $urandom_range(99);
        if (roll < (last_failed ? 70 : (clean_chain ? 0 : 4))) begin
            it.action   = ACT_RESTART;
            it.kind     = 3'($urandom());
            it.qwc      = 16'($urandom());
            it.addr     = ADDR_W'($urandom());
            it.spr      = 1'($urandom());
            clean_chain = ($urandom_range(99) < 35);
            return it;
        end

        // Noise, or a tag at an offset that cannot hold one anyway.
        if ((!clean_chain && $urandom_range(99) < 8) || off + 16 > lim) begin
            it.kind = 3'($urandom());
            it.qwc  = 16'($urandom());
            it.addr = ADDR_W'($urandom());
            it.spr  = 1'($urandom());
            return it;
        end

        // Payload size within the memory left after this tag.
        maxq = (lim - off - 16) / 16;
        if (maxq > 32'hFFFF) maxq = 32'hFFFF;
        roll = $urandom_range(99);
        if (roll < 70) it.qwc = 16'($urandom_range((maxq < 8) ? maxq : 8));
        else if (roll < 95) it.qwc = 16'($urandom_range((maxq < 1024) ? maxq : 1024));
        else it.qwc = 16'($urandom_range(maxq));
        size = 32'(it.qwc) * 16;

        case (it.kind)
            KIND_CNT: it.addr = '0;
            KIND_NEXT: begin
                nxt  = off + 16 + size;
                roll = $urandom_range(99);
                if (!clean_chain && seen_cnt > 0 && roll < 15) begin
                    nxt = 32'(seen_offs[$urandom_range(seen_cnt - 1)]);
                end else if (!clean_chain && roll < 30) begin
                    nxt = $urandom_range(lim / 16) * 16;
                end else if (nxt + 64 <= lim) begin
                    nxt = nxt + 16 * $urandom_range(4);
                end
                it.addr = ADDR_W'(nxt);
            end
            default: it.addr = ADDR_W'($urandom_range(lim - size));
        endcase

        // Occasionally break an otherwise good tag.
        if (!clean_chain) begin
            roll = $urandom_range(99);
            if (roll < 3) begin
                it.spr = 1'b1;
            end else if (roll < 6) begin
                it.kind = 3'($urandom_range(32'(KIND_RSVD_HI), 32'(KIND_RSVD_LO)));
            end else if (roll < 9) begin
                it.kind = KIND_CNT;
                it.addr = ADDR_W'($urandom_range(32'h7FFF_FFFF, 1));
            end else if (roll < 12) begin
                it.kind = KIND_NEXT;
                it.addr = ADDR_W'($urandom());
            end else if (roll < 15) begin
                it.kind = KIND_REF;
                it.addr = ADDR_W'($urandom());
            end
        end
        return it;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Predicts one item, stores its result, and offers it until the transfer.
    // Entered and left just after a falling edge, with valid left high.
    task automatic post_tag_item(input t_tag_item it, input logic fixed,
                                 input t_walk_result want);
        t_walk_result pred;
        pred        = follow_tag(it);
        last_failed = (it.action == ACT_TAG) && !pred.ok;
        due_results.push_back(fixed ? want : pred);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_action    <= it.action;
        i_tag_kind  <= it.kind;
        i_tag_qwc   <= it.qwc;
        i_tag_addr  <= it.addr;
        i_tag_spr   <= it.spr;
        i_vif_word0 <= it.word0;
        i_vif_word1 <= it.word1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // One configuration access: setup phase, then access until pready.
    task automatic apb_xfer(input logic wr, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
    endtask

    // Writes both registers, reads each one back, and updates the predictor.
    task automatic program_walker(input logic [OFF_W-1:0] limit,
                                  input logic [OFF_W-1:0] start);
        logic [31:0] rd;
        apb_xfer(1'b1, {CFG_MEM_LIMIT, 2'b00}, 32'(limit), rd);
        apb_xfer(1'b0, {CFG_MEM_LIMIT, 2'b00}, '0, rd);
        check_field("memory_limit readback", 64'(limit), 64'(rd[OFF_W-1:0]));
        apb_xfer(1'b1, {CFG_START_OFF, 2'b00}, 32'(start), rd);
        apb_xfer(1'b0, {CFG_START_OFF, 2'b00}, '0, rd);
        check_field("start register readback", 64'(start), 64'(rd[OFF_W-1:0]));
        @(negedge i_clk);
        psel      <= 1'b0;
        penable   <= 1'b0;
        cfg_limit = limit;
        cfg_start = start;
    endtask

    // Receiver: stalls at random at the phase's rate.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare every output transfer with the oldest result due.
    always @(posedge i_clk) begin
        t_walk_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_results.size() == 0) begin
                $error("output transfer with no result due");
                mismatches++;
            end else begin
                want = due_results.pop_front();
                check_field("ok", 64'(want.ok), 64'(o_ok));
                check_field("error_code", 64'(want.err), 64'(o_error_code));
                check_field("tag_off", 64'(want.tag_off), 64'(o_tag_off));
                check_field("data_off", 64'(want.data_off), 64'(o_data_off));
                check_field("byte_count", 64'(want.size), 64'(o_byte_count));
                check_field("vif_out0", 64'(want.out0), 64'(o_vif_out0));
                check_field("vif_out1", 64'(want.out1), 64'(o_vif_out1));
                check_field("current_offset", 64'(want.cur), 64'(o_current_offset));
            end
        end
    end

    // Watchdog: ends the run after too long without any transfer.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("dma_tag_chain_follower_core regression: fail");
            $finish;
        end
    end

    // Main sequence: reset, directed table, then the random phases.
    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int unsigned r = 0; r < DIR_ROWS; r++) begin
            post_tag_item(dir_table[r].stim, dir_table[r].fixed, dir_table[r].want);
        end

        for (int unsigned p = 0; p < PHASES; p++) begin
            // Registers change only once every result is back.
            if (p != 0) begin
                i_in_valid <= 1'b0;
                while (due_results.size() != 0) @(posedge i_clk);
                program_walker(phase_table[p].limit, phase_table[p].start);
            end
            send_idle_pct  = phase_table[p].send_pct;
            recv_stall_pct = phase_table[p].recv_pct;
            for (int unsigned k = 0; k < phase_table[p].count; k++) begin
                // Halfway through, hold off until the block has drained.
                if (k == phase_table[p].count / 2) begin
                    i_in_valid <= 1'b0;
                    while (due_results.size() != 0) @(posedge i_clk);
                    @(negedge i_clk);
                end
                post_tag_item(pick_walk_item(), 1'b0, NO_CHECK);
            end
        end

        // Let the last results out, then watch for stray transfers.
        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("dma_tag_chain_follower_core regression: pass");
        end else begin
            $display("dma_tag_chain_follower_core regression: fail");
        end
        $finish;
    end

endmodule
